[rtl/assert_macros.svh]
// assertion helpers for the pso update core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSO_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSO_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`else
`define PSO_ASSERT(label, clk, rst_n, prop, msg)
`define PSO_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

[rtl/pso_pkg.sv]
`default_nettype none
package pso_pkg;
	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_INERTIA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LO_BOUNCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HI_BOUNCE = 2'd2;
	localparam logic [15:0] INERTIA_RST = 16'd6554;
	localparam logic [1:0] BOUNCE_RST = 2'b11;
	localparam logic [16:0] RHO_FOUR = 17'd16384;
	localparam logic [16:0] CHI_ONE = 17'd65536;
	localparam int unsigned SQRT_STEPS = 17;

	typedef struct packed {
		logic [15:0] w;
		logic signed [1:0] lo_bounce;
		logic signed [1:0] hi_bounce;
	} cfg_t;
endpackage
`default_nettype wire

[rtl/pso_chi.sv]
`default_nettype none
// constriction factor: pipelined restoring sqrt then a pipelined divide
module pso_chi (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic [15:0] c1,
	input wire logic [15:0] c2,
	output logic signed [17:0] chi
);
	import pso_pkg::*;
	localparam int unsigned NS = SQRT_STEPS;
	localparam int unsigned ND = 30;
	// sqrt stage arrays
	logic [33:0] rem_s [0:NS];
	logic [33:0] rad_s [0:NS];
	logic [16:0] root_s [0:NS];
	logic [16:0] rho_s [0:NS];
	// divide arrays: 2^29 / dv, dv in 18 bits
	logic [17:0] dv_s [0:ND];
	logic [18:0] drem_s [0:ND];
	logic [29:0] quo_s [0:ND];
	logic big_s [0:ND];
	logic [16:0] rho0;
	logic [33:0] prod_s1;
	logic [16:0] rho_p;

	assign rho0 = {1'b0, c1} + {1'b0, c2};
	// product stage, rho*(rho-4) non negative when rho>4
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= (rho0 > RHO_FOUR) ? rho0 * (rho0 - RHO_FOUR) : 34'd0;
			rho_p <= rho0;
		end
	end
	always_comb begin
		rad_s[0] = prod_s1;
		rem_s[0] = '0;
		root_s[0] = '0;
		rho_s[0] = rho_p;
	end
	for (genvar i = 0; i < NS; i++) begin : g_sq
		logic [33:0] trial;
		logic [33:0] nrem;
		always_comb begin
			nrem = {rem_s[i][31:0], rad_s[i][33:32]};
			trial = {15'd0, root_s[i], 2'b01};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (nrem >= trial) begin
					rem_s[i+1] <= nrem - trial;
					root_s[i+1] <= {root_s[i][15:0], 1'b1};
				end else begin
					rem_s[i+1] <= nrem;
					root_s[i+1] <= {root_s[i][15:0], 1'b0};
				end
				rad_s[i+1] <= {rad_s[i][31:0], 2'b00};
				rho_s[i+1] <= rho_s[i];
			end
		end
	end
	// -D = rho + S - 8192, positive when rho > 4.0
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= {1'b0, rho_s[NS]} + {1'b0, root_s[NS]} - 18'd8192;
			big_s[0] <= rho_s[NS] > RHO_FOUR;
		end
	end
	always_comb begin
		drem_s[0] = '0;
		quo_s[0] = '0;
	end
	for (genvar j = 0; j < ND; j++) begin : g_dv
		logic [18:0] nr;
		logic bitin;
		always_comb begin
			bitin = (j == 0);
			nr = {drem_s[j][17:0], bitin};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (nr >= {1'b0, dv_s[j]}) begin
					drem_s[j+1] <= nr - {1'b0, dv_s[j]};
					quo_s[j+1] <= {quo_s[j][28:0], 1'b1};
				end else begin
					drem_s[j+1] <= nr;
					quo_s[j+1] <= {quo_s[j][28:0], 1'b0};
				end
				dv_s[j+1] <= dv_s[j];
				big_s[j+1] <= big_s[j];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			chi <= big_s[ND] ? -$signed({1'b0, quo_s[ND][16:0]}) : $signed({1'b0, CHI_ONE});
		end
	end
	logic unused_ok;
	assign unused_ok = &{1'b0, quo_s[ND][29:17], arst_n};
endmodule
`default_nettype wire

[rtl/pso_velocity_position_update_core.sv]
`default_nettype none
// throughput: one word per cycle while the output is not stalled; the constriction sqrt and divide are fully pipelined
// the whole pipe advances together whenever the output register is free or taken
// reset: asynchronous active low, clears valid bits and loads the register defaults
module pso_velocity_position_update_core #(
	parameter int unsigned VALUE_WIDTH = pso_pkg::VALUE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [31:0] position,
	input wire logic signed [31:0] current_speed,
	input wire logic signed [31:0] personal_best,
	input wire logic signed [31:0] global_best,
	input wire logic [15:0] rand_cognitive,
	input wire logic [15:0] rand_social,
	input wire logic [15:0] coef_cognitive,
	input wire logic [15:0] coef_social,
	input wire logic signed [31:0] lower_bound,
	input wire logic signed [31:0] upper_bound,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] new_position,
	output logic signed [31:0] new_speed,
	output logic hit_lower,
	output logic hit_upper,
	input wire logic cfg_we,
	input wire logic [pso_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [pso_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pso_pkg::*;
`include "assert_macros.svh"
	// chi path: 1 product + 17 sqrt + 1 + 30 div + 1 out = 50 stages
	localparam int unsigned ND_C = 30;
	localparam int unsigned CHI_LAT = SQRT_STEPS + ND_C + 3;
	localparam int unsigned DEPTH = CHI_LAT + 3;
	localparam int unsigned SW = 66;

	cfg_t cfg_q;
	logic adv;
	logic [DEPTH-1:0] vld_q;
	logic signed [17:0] chi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{w: INERTIA_RST, lo_bounce: BOUNCE_RST, hi_bounce: BOUNCE_RST};
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_INERTIA: cfg_q.w <= cfg_data;
				REG_LO_BOUNCE: cfg_q.lo_bounce <= cfg_data[1:0];
				REG_HI_BOUNCE: cfg_q.hi_bounce <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// whole pipe moves when output slot is empty or being taken
	assign adv = !vld_q[DEPTH-1] || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEPTH-2:0], in_valid};
	end

	pso_chi u_chi (.clk, .arst_n, .adv, .c1(coef_cognitive), .c2(coef_social), .chi);

	// stage 1: k products and differences
	logic [31:0] k1_s1, k2_s1, wv_u;
	logic signed [32:0] d1_s1, d2_s1;
	logic signed [31:0] v_s1;
	// stage 2: weighted terms
	logic signed [49:0] wv_s2;
	logic signed [53:0] t1_s2, t2_s2;
	// stage 3: sum shifted
	logic signed [SW-1:0] sum_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			k1_s1 <= coef_cognitive * rand_cognitive;
			k2_s1 <= coef_social * rand_social;
			d1_s1 <= 33'(personal_best) - 33'(position);
			d2_s1 <= 33'(global_best) - 33'(position);
			v_s1 <= current_speed;
			wv_s2 <= $signed({1'b0, cfg_q.w}) * v_s1;
			t1_s2 <= $signed({1'b0, k1_s1[31:12]}) * d1_s1;
			t2_s2 <= $signed({1'b0, k2_s1[31:12]}) * d2_s1;
			sum_s3 <= (SW'(wv_s2) + SW'(t1_s2) + SW'(t2_s2)) >>> 16;
		end
	end
	assign wv_u = '0;

	// delay sum, position and bounds to meet chi
	localparam int unsigned DL = CHI_LAT - 3;
	logic signed [49:0] sd_q [0:DL];
	logic signed [31:0] xd_q [0:DL];
	logic signed [31:0] lod_q [0:DL];
	logic signed [31:0] hid_q [0:DL];
	logic signed [31:0] x_s1, x_s2, lo_s1, lo_s2, hi_s1, hi_s2;
	logic signed [31:0] x_s3, lo_s3, hi_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= position; lo_s1 <= lower_bound; hi_s1 <= upper_bound;
			x_s2 <= x_s1; lo_s2 <= lo_s1; hi_s2 <= hi_s1;
			x_s3 <= x_s2; lo_s3 <= lo_s2; hi_s3 <= hi_s2;
		end
	end
	always_comb begin
		sd_q[0] = sum_s3[49:0];
		xd_q[0] = x_s3; lod_q[0] = lo_s3; hid_q[0] = hi_s3;
	end
	for (genvar i = 0; i < DL; i++) begin : g_dl
		always_ff @(posedge clk) begin
			if (adv) begin
				sd_q[i+1] <= sd_q[i]; xd_q[i+1] <= xd_q[i];
				lod_q[i+1] <= lod_q[i]; hid_q[i+1] <= hid_q[i];
			end
		end
	end

	// chi multiply: 18 x 50 product, scaled back to Q16.16 into the stage register
	logic signed [68:0] raw_full;
	logic signed [52:0] raw_s4;
	logic signed [31:0] x_s4, lo_s4, hi_s4;
	assign raw_full = chi * sd_q[DL];
	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s4 <= 53'(raw_full >>> 16);
			x_s4 <= xd_q[DL]; lo_s4 <= lod_q[DL]; hi_s4 <= hid_q[DL];
		end
	end

	// speed clamp and position
	logic signed [32:0] dmax;
	logic signed [52:0] spd_c;
	logic signed [53:0] pos_c;
	always_comb begin
		dmax = (33'(hi_s4) - 33'(lo_s4)) >>> 1;
		spd_c = raw_s4;
		if (raw_s4 > 53'(dmax)) spd_c = 53'(dmax);
		if (raw_s4 < -53'(dmax)) spd_c = -53'(dmax);
		pos_c = 54'(x_s4) + 54'(spd_c);
	end
	logic signed [52:0] spd_s5;
	logic signed [53:0] pos_s5;
	logic signed [31:0] lo_s5, hi_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			spd_s5 <= spd_c; pos_s5 <= pos_c; lo_s5 <= lo_s4; hi_s5 <= hi_s4;
		end
	end

	// bound clamp, bounce, saturate
	logic signed [53:0] pos_f;
	logic signed [56:0] spd_f;
	logic hl_c, hu_c;
	logic signed [63:0] vmax;
	logic signed [31:0] pos_o, spd_o;
	always_comb begin
		pos_f = pos_s5;
		spd_f = 57'(spd_s5);
		hl_c = 1'b0;
		hu_c = 1'b0;
		if (pos_f < 54'(lo_s5)) begin
			pos_f = 54'(lo_s5);
			spd_f = 57'(spd_f * cfg_q.lo_bounce);
			hl_c = 1'b1;
		end
		if (pos_f > 54'(hi_s5)) begin
			pos_f = 54'(hi_s5);
			spd_f = 57'(spd_f * cfg_q.hi_bounce);
			hu_c = 1'b1;
		end
		vmax = 64'((65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1);
		pos_o = 32'(pos_f);
		spd_o = 32'(spd_f);
		if (64'(pos_f) > vmax) pos_o = 32'(vmax);
		if (64'(pos_f) < -vmax - 64'sd1) pos_o = 32'(-vmax - 64'sd1);
		if (64'(spd_f) > vmax) spd_o = 32'(vmax);
		if (64'(spd_f) < -vmax - 64'sd1) spd_o = 32'(-vmax - 64'sd1);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			new_position <= pos_o; new_speed <= spd_o;
			hit_lower <= hl_c; hit_upper <= hu_c;
		end
	end
	assign out_valid = vld_q[DEPTH-1];

	logic unused_ok;
	assign unused_ok = &{1'b0, wv_u, k1_s1[11:0], k2_s1[11:0], sum_s3[SW-1:50]};

	`PSO_ASSERT(a_stall_adv, clk, arst_n, in_stall == (out_valid && out_stall), "stall mismatch")
	`PSO_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, $stable(new_position), "output moved")
	`PSO_ASSERT_NEXT(a_valid_hold, clk, arst_n, out_valid && out_stall, out_valid, "output word dropped")
endmodule
`default_nettype wire
